@@ src/rgbfog_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbfog_pkg
// Shared types and constants for the 16-bit fog colour adjust block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbfog_pkg;

   // Mask byte that marks a pixel for fogging
   localparam logic [7:0] FOG_MARK = 8'd239;

   // Channel arithmetic constants
   localparam int unsigned FOG_DIVISOR      = 30000;
   localparam int unsigned FOG_BRIGHT_SCALE = 76800;
   localparam int unsigned FOG_GRAY_SCALE   = 100;

   // Non-negative sums at or above this clamp to 255
   localparam logic [28:0] CLAMP_LIMIT = 29'(256 * FOG_DIVISOR);

   // floor(x / 30000) == (x * RECIP) >> RECIP_SHIFT for all x < 2^23
   localparam int unsigned RECIP_SHIFT = 38;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + 64'(FOG_DIVISOR) - 64'd1) / 64'(FOG_DIVISOR);
   localparam logic [23:0] RECIP = 24'(RECIP_FULL);

   // Register indexes
   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_SATURATION   = 2'd1,
      CSR_CONTRAST     = 2'd2,
      CSR_BRIGHTNESS   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic       pixel_format;   // 1 = RGB565, 0 = RGB555
      logic [7:0] saturation;
      logic [7:0] contrast;
      logic [6:0] brightness;
   } cfg_type;

   // Load enables of the channel pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } adv_type;

endpackage

`default_nettype wire

@@ src/rgb16_fog_color_adjust.sv @@
// ----------------------------------------------------------------------------
// rgb16_fog_color_adjust
// Fog tint for 16-bit RGB555/RGB565 pixels with saturation, contrast and
// brightness controls, one word per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// A user's note: the block takes one pixel word per clock while the result
// side does not stall, and returns one pixel word for each, in order. The
// channel datapath holds deviation from gray, the saturation multiply, the
// contrast multiply and the clamp with a reciprocal multiply for the divide
// by 30000, each behind its own register. Stages move independently, so
// bubbles are squeezed out and a new word is still taken while the output
// register waits, as long as a stage before it is free. Pixels whose mask
// byte is 239, or that carry the force bit, are adjusted; all others leave
// unchanged. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb16_fog_color_adjust (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_pixel_in,
   input  wire logic [7:0]  req_mask_index,
   input  wire logic        req_force_req,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pixel_out,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import rgbfog_pkg::*;

   cfg_type cfg;
   adv_type en;
   logic    en_out;

   // --- configuration ------------------------------------------------------
   rgbfog_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // --- stage control ------------------------------------------------------
   // A stage loads when it is empty or its word moves on in the same cycle.
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en.s3     = !v3_ff || en_out;
   assign en.s2     = !v2_ff || en.s3;
   assign en.s1     = !v1_ff || en.s2;
   assign req_ready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req_valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en_out) rsp_valid_ff <= v3_ff;
      end
   end

   // --- unpack -------------------------------------------------------------
   // Channels widened to 8 bits with zero low bits; bit 15 ignored in RGB555.
   logic [7:0] r8, g8, b8;
   logic [9:0] sum;
   logic       fog_in;

   assign r8 = {req_pixel_in[4:0], 3'b000};
   assign g8 = cfg.pixel_format ? {req_pixel_in[10:5], 2'b00}
                                : {req_pixel_in[9:5], 3'b000};
   assign b8 = cfg.pixel_format ? {req_pixel_in[15:11], 3'b000}
                                : {req_pixel_in[14:10], 3'b000};
   assign sum    = 10'(r8) + 10'(g8) + 10'(b8);
   assign fog_in = req_force_req || (req_mask_index == FOG_MARK);

   // --- pass-through word and fog flag travel beside the datapath ---------
   logic [15:0] pix1_ff, pix2_ff, pix3_ff;
   logic        fog1_ff, fog2_ff, fog3_ff;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         pix1_ff <= req_pixel_in;
         fog1_ff <= fog_in;
      end
      if (en.s2) begin
         pix2_ff <= pix1_ff;
         fog2_ff <= fog1_ff;
      end
      if (en.s3) begin
         pix3_ff <= pix2_ff;
         fog3_ff <= fog2_ff;
      end
   end

   // --- channel datapaths --------------------------------------------------
   logic [7:0] r_adj, g_adj, b_adj;

   rgbfog_chan u_chan_r (
      .clock    (clock),
      .cfg      (cfg),
      .en       (en),
      .chan_in  (r8),
      .sum_in   (sum),
      .chan_out (r_adj)
   );

   rgbfog_chan u_chan_g (
      .clock    (clock),
      .cfg      (cfg),
      .en       (en),
      .chan_in  (g8),
      .sum_in   (sum),
      .chan_out (g_adj)
   );

   rgbfog_chan u_chan_b (
      .clock    (clock),
      .cfg      (cfg),
      .en       (en),
      .chan_in  (b8),
      .sum_in   (sum),
      .chan_out (b_adj)
   );

   // --- repack and output register -----------------------------------------
   logic [15:0] packed_pix;
   logic [15:0] rsp_pixel_ff;
   logic [15:0] rsp_pixel_in;

   assign packed_pix = cfg.pixel_format ? {b_adj[7:3], g_adj[7:2], r_adj[7:3]}
                                        : {1'b0, b_adj[7:3], g_adj[7:3], r_adj[7:3]};
   assign rsp_pixel_in = fog3_ff ? packed_pix : pix3_ff;

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_pixel_ff <= rsp_pixel_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   // --- assertions ---------------------------------------------------------
`ifndef SYNTHESIS
   // back-pressure reaches the input only with every stage occupied
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("request side stalled with a free stage");

   // a held stage 3 keeps its word
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !en.s3) |=> (v3_ff && $stable(pix3_ff) && $stable(fog3_ff)))
      else $error("stalled stage 3 word changed");

   // an adjusted RGB555 pixel leaves with bit 15 clear
   a_rgb555_top_bit: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en_out && fog3_ff && !cfg.pixel_format) |=> !rsp_pixel_out[15])
      else $error("adjusted RGB555 pixel has bit 15 set");
`endif

endmodule

`default_nettype wire

@@ src/rgbfog_csr.sv @@
// ----------------------------------------------------------------------------
// rgbfog_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbfog_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [7:0]         csr_wdata,
   output rgbfog_pkg::cfg_type     cfg
);
   import rgbfog_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PIXEL_FORMAT: cfg_in.pixel_format = csr_wdata[0];
            CSR_SATURATION:   cfg_in.saturation   = csr_wdata;
            CSR_CONTRAST:     cfg_in.contrast     = csr_wdata;
            CSR_BRIGHTNESS:   cfg_in.brightness   = csr_wdata[6:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= 1'b1;
         cfg_ff.saturation   <= 8'd40;
         cfg_ff.contrast     <= 8'd50;
         cfg_ff.brightness   <= 7'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/rgbfog_chan.sv @@
// ----------------------------------------------------------------------------
// rgbfog_chan
// Three-stage arithmetic for one colour channel: deviation from gray,
// saturation and contrast products, then clamp and divide by 30000.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbfog_chan (
   input  wire logic                clock,
   input  wire rgbfog_pkg::cfg_type cfg,
   input  wire rgbfog_pkg::adv_type en,
   input  wire logic [7:0]          chan_in,
   input  wire logic [9:0]          sum_in,
   output logic [7:0]               chan_out
);
   import rgbfog_pkg::*;

   // stage 1: 3c - v and 100v
   logic [10:0]        c3;
   logic signed [10:0] dev_in;
   logic signed [10:0] dev_ff;
   logic [16:0]        v100_in;
   logic [16:0]        v100_ff;

   // stage 2: dev*sat + 100v
   logic signed [19:0] prod1;
   logic signed [19:0] t1_in;
   logic signed [19:0] t1_ff;

   // stage 3: t1*con + bri*76800
   logic signed [28:0] prod2;
   logic [23:0]        bri_off;
   logic signed [28:0] t2_in;
   logic signed [28:0] t2_ff;

   // clamp and reciprocal divide
   logic [46:0]        rprod;

   assign c3      = 11'(chan_in) * 11'd3;
   assign dev_in  = $signed(c3 - {1'b0, sum_in});
   assign v100_in = 17'(sum_in) * 17'(FOG_GRAY_SCALE);

   assign prod1 = dev_ff * $signed({1'b0, cfg.saturation});
   assign t1_in = prod1 + $signed({3'b000, v100_ff});

   assign bri_off = 24'(cfg.brightness) * 24'(FOG_BRIGHT_SCALE);
   assign prod2   = t1_ff * $signed({1'b0, cfg.contrast});
   assign t2_in   = prod2 + $signed({5'b00000, bri_off});

   always_ff @(posedge clock) begin
      if (en.s1) begin
         dev_ff  <= dev_in;
         v100_ff <= v100_in;
      end
      if (en.s2) begin
         t1_ff <= t1_in;
      end
      if (en.s3) begin
         t2_ff <= t2_in;
      end
   end

   // below the clamp limit the sum fits 23 bits
   assign rprod = 47'(t2_ff[22:0]) * 47'(RECIP);

   always_comb begin
      priority if (t2_ff[28]) begin
         chan_out = 8'd0;
      end else if ($unsigned(t2_ff) >= CLAMP_LIMIT) begin
         chan_out = 8'd255;
      end else begin
         chan_out = rprod[RECIP_SHIFT +: 8];
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_rgb16_fog_color_adjust.sv @@
// ----------------------------------------------------------------------------
// tb_rgb16_fog_color_adjust
// Self-checking bench for the 16-bit fog colour adjust block. A behavioural
// predictor works out the expected pixel word for every accepted request, and
// each response word is compared in order against it. Directed tests cover the
// reset settings, mask selection, RGB555 bit 15 and clamping at both ends.
// Random traffic then runs under several register settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rgb16_fog_color_adjust;

   timeunit 1ns;
   timeprecision 1ps;

   import rgbfog_pkg::*;

   // Settle time after the last response before a register write or the end;
   // the datapath is four stages deep
   localparam int DRAIN_CYCLES = 8;
   // Far above the slowest plausible run (~2k words, heavy stalls)
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ROUNDS = 9;
   localparam int WORDS_PER_ROUND = 206;

   // Signed copies of the channel constants so the predictor stays signed
   localparam longint DIVISOR      = FOG_DIVISOR;
   localparam longint BRIGHT_SCALE = FOG_BRIGHT_SCALE;
   localparam longint GRAY_SCALE   = FOG_GRAY_SCALE;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [15:0] req_pixel_in   = '0;
   logic [7:0]  req_mask_index = '0;
   logic        req_force_req  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [15:0] rsp_pixel_out;
   logic        csr_we         = 1'b0;
   csr_idx_type csr_index      = CSR_PIXEL_FORMAT;
   logic [7:0]  csr_wdata      = '0;

   // Bench copy of the block's registers, matching their reset values
   cfg_type     fog_cfg = '{pixel_format: 1'b1, saturation: 8'd40,
                            contrast: 8'd50, brightness: 7'd10};

   logic [15:0] pending_pixels[$];   // predicted words, oldest first
   int          mismatches   = 0;
   int          cycle_count  = 0;
   int          src_idle_pct = 0;    // chance per cycle of holding a word back
   int          dst_idle_pct = 0;    // chance per cycle of stalling the output

   rgb16_fog_color_adjust u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .req_mask_index (req_mask_index),
      .req_force_req  (req_force_req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // One channel, widened to 8 bits; divide truncates toward zero, then clamp
   function automatic logic [7:0] fog_level(input longint chan, input longint sum);
      longint sat;
      longint con;
      longint bri;
      longint acc;
      sat = fog_cfg.saturation;
      con = fog_cfg.contrast;
      bri = fog_cfg.brightness;
      acc = (3 * chan - sum) * sat + sum * GRAY_SCALE;
      acc = acc * con + bri * BRIGHT_SCALE;
      acc = acc / DIVISOR;
      if (acc < 0) begin
         return 8'd0;
      end
      if (acc > 255) begin
         return 8'd255;
      end
      return acc[7:0];
   endfunction

   function automatic logic [15:0] fogged_pixel(input logic [15:0] px);
      longint     r8;
      longint     g8;
      longint     b8;
      longint     sum;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r8 = {px[4:0], 3'b000};
      if (fog_cfg.pixel_format) begin
         g8 = {px[10:5], 2'b00};
         b8 = {px[15:11], 3'b000};
      end else begin
         // RGB555: bit 15 plays no part
         g8 = {px[9:5], 3'b000};
         b8 = {px[14:10], 3'b000};
      end
      sum = r8 + g8 + b8;
      r = fog_level(r8, sum);
      g = fog_level(g8, sum);
      b = fog_level(b8, sum);
      if (fog_cfg.pixel_format) begin
         return {b[7:3], g[7:2], r[7:3]};
      end
      return {1'b0, b[7:3], g[7:3], r[7:3]};
   endfunction

   function automatic logic [15:0] expected_pixel(input logic [15:0] px,
                                                  input logic [7:0]  mask,
                                                  input logic        frc);
      if (frc || mask == FOG_MARK) begin
         return fogged_pixel(px);
      end
      return px;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stalls, in-order compare, run timeout
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= dst_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h", $time, rsp_pixel_out);
            mismatches++;
         end else begin
            if (rsp_pixel_out !== pending_pixels[0]) begin
               $display("%0t: pixel_out expected %h, got %h",
                        $time, pending_pixels[0], rsp_pixel_out);
               mismatches++;
            end
            void'(pending_pixels.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run timed out, %0d words outstanding", $time, pending_pixels.size());
         $display("rgb16_fog_color_adjust: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Shared tasks; all are entered and left just after a rising edge
   // ------------------------------------------------------------------------

   // Offer one word with random idle cycles ahead; the prediction is queued
   // at the edge that accepts it
   task automatic send_pixel(input logic [15:0] px, input logic [7:0] mask,
                             input logic frc);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_in   <= px;
      req_mask_index <= mask;
      req_force_req  <= frc;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_pixels.push_back(expected_pixel(px, mask, frc));
   endtask

   // Every word gives a response, so an empty queue plus a short pause
   // means the pipeline is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all four registers on consecutive edges; the block must be idle
   task automatic set_config(input logic fmt, input logic [7:0] sat,
                             input logic [7:0] con, input logic [6:0] bri);
      csr_we    <= 1'b1;
      csr_index <= CSR_PIXEL_FORMAT;
      csr_wdata <= {7'd0, fmt};
      @(posedge clock);
      csr_index <= CSR_SATURATION;
      csr_wdata <= sat;
      @(posedge clock);
      csr_index <= CSR_CONTRAST;
      csr_wdata <= con;
      @(posedge clock);
      csr_index <= CSR_BRIGHTNESS;
      csr_wdata <= {1'b0, bri};
      @(posedge clock);
      csr_we <= 1'b0;
      fog_cfg.pixel_format = fmt;
      fog_cfg.saturation   = sat;
      fog_cfg.contrast     = con;
      fog_cfg.brightness   = bri;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Settings straight out of reset, RGB565
   task automatic test_reset_config();
      send_pixel(16'hFFFF, FOG_MARK, 1'b0);
      send_pixel(16'h0000, 8'h00, 1'b1);
      send_pixel(16'hF81F, FOG_MARK, 1'b0);
      send_pixel(16'h07E0, FOG_MARK, 1'b1);
      wait_drained();
   endtask

   // Only mask 239 or the force bit selects the pixel
   task automatic test_mask_select();
      send_pixel(16'h1234, 8'd238, 1'b0);
      send_pixel(16'hBEEF, 8'd240, 1'b0);
      send_pixel(16'hFFFF, 8'h00, 1'b0);
      send_pixel(16'h0000, 8'hFF, 1'b0);
      send_pixel(16'hA5A5, 8'h10, 1'b1);
      send_pixel(16'h5A5A, FOG_MARK, 1'b1);
      wait_drained();
   endtask

   // RGB555: bit 15 ignored when fogged, kept when passed through
   task automatic test_rgb555();
      set_config(1'b0, 8'd40, 8'd50, 7'd10);
      send_pixel(16'h8000, FOG_MARK, 1'b0);
      send_pixel(16'hFFFF, FOG_MARK, 1'b0);
      send_pixel(16'h7FFF, 8'h00, 1'b1);
      send_pixel(16'hFFFF, 8'h00, 1'b0);
      wait_drained();
   endtask

   // Negative channels clamp to 0, large ones to 255; registers above range
   task automatic test_clamping();
      set_config(1'b1, 8'd255, 8'd255, 7'd0);
      send_pixel(16'h001F, FOG_MARK, 1'b0);
      send_pixel(16'hFFFF, 8'h00, 1'b1);
      wait_drained();
      set_config(1'b0, 8'd255, 8'd255, 7'd127);
      send_pixel(16'h7C00, FOG_MARK, 1'b0);
      send_pixel(16'h03E0, 8'h00, 1'b1);
      wait_drained();
      set_config(1'b1, 8'd0, 8'd0, 7'd0);
      send_pixel(16'h1234, FOG_MARK, 1'b0);
      send_pixel(16'hFFFF, FOG_MARK, 1'b0);
      wait_drained();
      set_config(1'b1, 8'd200, 8'd200, 7'd100);
      send_pixel(16'hF800, FOG_MARK, 1'b0);
      send_pixel(16'h0000, 8'h00, 1'b1);
      wait_drained();
   endtask

   // Rounds of random words, each under its own register setting; the idle
   // pattern moves from a slow receiver to a slow sender to none at all
   task automatic test_random_traffic();
      logic [7:0] mask;
      logic       frc;
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         if (round < 3) begin
            src_idle_pct = 30;
            dst_idle_pct = 47;
         end else if (round < 6) begin
            src_idle_pct = 47;
            dst_idle_pct = 30;
         end else begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
         end
         case (round)
            0: set_config(1'b0, 8'd0, 8'd0, 7'd0);
            1: set_config(1'b1, 8'd200, 8'd200, 7'd100);
            2: set_config(1'b0, 8'd255, 8'd255, 7'd127);
            8: set_config(1'($urandom_range(1)), 8'($urandom_range(255)),
                          8'($urandom_range(255)), 7'($urandom_range(127)));
            default: set_config(1'($urandom_range(1)), 8'($urandom_range(200)),
                                8'($urandom_range(200)), 7'($urandom_range(100)));
         endcase
         for (int n = 0; n < WORDS_PER_ROUND; n++) begin
            // Mostly fogged words; the rest check the pass-through path
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  mask = FOG_MARK;
                  frc  = 1'b0;
               end
               4, 5, 6: begin
                  mask = 8'($urandom_range(255));
                  frc  = 1'b1;
               end
               default: begin
                  mask = 8'($urandom_range(255));
                  frc  = 1'b0;
               end
            endcase
            send_pixel(16'($urandom_range(16'hFFFF)), mask, frc);
         end
         wait_drained();
      end
   endtask

   initial begin
      src_idle_pct = 30;
      dst_idle_pct = 47;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_mask_select();
      test_rgb555();
      test_clamping();
      test_random_traffic();
      if (mismatches == 0) begin
         $display("rgb16_fog_color_adjust: match");
      end else begin
         $display("rgb16_fog_color_adjust: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
